// ----- rtl/shallow_water_rusanov_flux_top_assert.svh -----
// Assertion macros for the shallow-water flux top level
`ifndef SHALLOW_WATER_RUSANOV_FLUX_TOP_ASSERT_SVH
`define SHALLOW_WATER_RUSANOV_FLUX_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define SWRF_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define SWRF_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/swrf_pkg.sv -----
// Shared constants, types and helper functions of the shallow-water flux unit
package swrf_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned IN_W   = 32;
  localparam int unsigned OUT_W  = 48;
  localparam int unsigned GRAV_W = 28;

  // integer square root: 60-bit radicand, 30-bit root, 4 root bits per stage
  localparam int unsigned SQ_IN_W   = 60;
  localparam int unsigned SQ_OUT_W  = 30;
  localparam int unsigned SQ_REM_W  = 34;
  localparam int unsigned SQ_BPS    = 4;
  localparam int unsigned SQ_STAGES = (SQ_OUT_W + SQ_BPS - 1) / SQ_BPS;

  localparam int unsigned SPD_W = 33;
  localparam int unsigned MA_W  = 64;
  localparam int unsigned MB_W  = 34;
  localparam int unsigned MP_W  = MA_W + MB_W;
  localparam int unsigned LO_W  = 32;
  localparam int unsigned ACC_W = 104;

  typedef struct packed {
    logic signed [IN_W-1:0] hl;
    logic signed [IN_W-1:0] hr;
    logic signed [IN_W-1:0] ul;
    logic signed [IN_W-1:0] ur;
    logic signed [IN_W-1:0] vl;
    logic signed [IN_W-1:0] vr;
    logic signed [MA_W-1:0] ql;
    logic signed [MA_W-1:0] qr;
    logic signed [MA_W-1:0] hvl;
    logic signed [MA_W-1:0] hvr;
    logic signed [MA_W-1:0] hgl;
    logic signed [MA_W-1:0] hgr;
    logic                   zero;
  } pay_t;

  typedef struct packed {
    logic signed [MA_W-1:0] ql;
    logic signed [MA_W-1:0] qr;
    logic                   zero;
  } mpay_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] mass;
    logic signed [OUT_W-1:0] normal;
    logic signed [OUT_W-1:0] trans;
  } res_t;

  // g = round(9.81 * 2^f)
  function automatic logic [31:0] grav_fx(input int unsigned f);
    logic [63:0] t;
    t = (64'd981 << f) + 64'd50;
    return 32'(t / 64'd100);
  endfunction

  // g/2 = round(4.905 * 2^f)
  function automatic logic [31:0] hgrav_fx(input int unsigned f);
    logic [63:0] t;
    t = (64'd4905 << f) + 64'd500;
    return 32'(t / 64'd1000);
  endfunction

endpackage

// ----- rtl/swrf_face_if.sv -----
// Input channel: one cell interface per word
interface swrf_face_if;
  import swrf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] depth_left;
  logic signed [IN_W-1:0] depth_right;
  logic signed [IN_W-1:0] normal_vel_left;
  logic signed [IN_W-1:0] normal_vel_right;
  logic signed [IN_W-1:0] trans_vel_left;
  logic signed [IN_W-1:0] trans_vel_right;

  modport source(output valid, depth_left, depth_right, normal_vel_left, normal_vel_right,
                 trans_vel_left, trans_vel_right, input ready);
  modport sink(input valid, depth_left, depth_right, normal_vel_left, normal_vel_right,
               trans_vel_left, trans_vel_right, output ready);
endinterface

// ----- rtl/swrf_flux_if.sv -----
// Output channel: three fluxes per word
interface swrf_flux_if;
  import swrf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] mass_flux;
  logic signed [OUT_W-1:0] normal_momentum_flux;
  logic signed [OUT_W-1:0] trans_momentum_flux;

  modport source(output valid, mass_flux, normal_momentum_flux, trans_momentum_flux,
                 input ready);
  modport sink(input valid, mass_flux, normal_momentum_flux, trans_momentum_flux,
               output ready);
endinterface

// ----- rtl/shallow_water_rusanov_flux_top.sv -----
// Top level of the 2-D shallow-water Rusanov flux pipeline
//
//  channel | dir | word
//  --------+-----+---------------------------------------------------------
//  face    | in  | hL, hR, uL, uR, vL, vR, signed Q16.16 (FRAC_BITS frac)
//  flux    | out | mass, normal momentum, transverse momentum, Q32.16 sat
//
// One word accepted per cycle while the output buffer is not full; the
// square root has 8 stages of 4 root bits.
// Reset (rst, synchronous) clears the stage valid bits and the output buffer.
// A two-entry output buffer sits after the last stage; only when it is full
// does the whole pipeline hold, and face.ready then drops from a register.
`include "shallow_water_rusanov_flux_top_assert.svh"

module shallow_water_rusanov_flux_top #(
  parameter int unsigned FRAC_BITS = swrf_pkg::FRAC_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  swrf_face_if.sink    face,
  swrf_flux_if.source  flux
);
  import swrf_pkg::*;

  localparam logic [GRAV_W-1:0] GRAV  = GRAV_W'(grav_fx(FRAC_BITS));
  localparam logic [GRAV_W-1:0] HGRAV = GRAV_W'(hgrav_fx(FRAC_BITS));
  localparam logic signed [MA_W-1:0] HGRAV_S = MA_W'(HGRAV);
  // halving folded into one extra dropped bit
  localparam int unsigned SH_M = FRAC_BITS + 1;
  localparam int unsigned SH_N = 2 * FRAC_BITS + 1;
  localparam logic signed [ACC_W-1:0] RND_M = ACC_W'(1) << (SH_M - 1);
  localparam logic signed [ACC_W-1:0] RND_N = ACC_W'(1) << (SH_N - 1);

  // round already added; arithmetic shift then clamp to the 48-bit range
  function automatic logic signed [OUT_W-1:0] finish(input logic signed [ACC_W-1:0] v,
                                                     input int unsigned sh);
    logic signed [ACC_W-1:0] s;
    logic [ACC_W-OUT_W:0]    hi;
    s  = v >>> sh;
    hi = s[ACC_W-1:OUT_W-1];
    if (&hi || ~|hi) begin
      return s[OUT_W-1:0];
    end else if (s[ACC_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  logic ce;

  // ---------------- stage 1: capture, first products ----------------
  logic [IN_W-2:0]    hcl_c, hcr_c;
  logic [SQ_IN_W-1:0] ghl_c, ghr_c;
  pay_t               p_c;

  assign hcl_c = face.depth_left[IN_W-1]  ? '0 : face.depth_left[IN_W-2:0];
  assign hcr_c = face.depth_right[IN_W-1] ? '0 : face.depth_right[IN_W-2:0];
  assign ghl_c = SQ_IN_W'(GRAV) * SQ_IN_W'(hcl_c);
  assign ghr_c = SQ_IN_W'(GRAV) * SQ_IN_W'(hcr_c);

  always_comb begin
    p_c.hl  = face.depth_left;
    p_c.hr  = face.depth_right;
    p_c.ul  = face.normal_vel_left;
    p_c.ur  = face.normal_vel_right;
    p_c.vl  = face.trans_vel_left;
    p_c.vr  = face.trans_vel_right;
    p_c.ql  = MA_W'(face.depth_left)  * MA_W'(face.normal_vel_left);
    p_c.qr  = MA_W'(face.depth_right) * MA_W'(face.normal_vel_right);
    p_c.hvl = MA_W'(face.depth_left)  * MA_W'(face.trans_vel_left);
    p_c.hvr = MA_W'(face.depth_right) * MA_W'(face.trans_vel_right);
    p_c.hgl = HGRAV_S * MA_W'(face.depth_left);
    p_c.hgr = HGRAV_S * MA_W'(face.depth_right);
    // both depths zero or negative
    p_c.zero = (face.depth_left[IN_W-1]  || face.depth_left  == '0) &&
               (face.depth_right[IN_W-1] || face.depth_right == '0);
  end

  logic               v1;
  pay_t               p1;
  logic [SQ_IN_W-1:0] ghl, ghr;

  // ---------------- square-root stages, payload rides alongside ----------------
  logic [SQ_OUT_W-1:0] rootl, rootr;
  logic                vsq [SQ_STAGES];
  pay_t                psq [SQ_STAGES];

  swrf_isqrt u_sqrt_l (.clk(clk), .ce(ce), .rad(ghl), .root(rootl));
  swrf_isqrt u_sqrt_r (.clk(clk), .ce(ce), .rad(ghr), .root(rootr));

  // ---------------- wave speed ----------------
  pay_t               pq;
  logic [IN_W-1:0]    aul_c, aur_c;
  logic [SPD_W-1:0]   spl_c, spr_c;
  assign pq    = psq[SQ_STAGES-1];
  assign aul_c = pq.ul[IN_W-1] ? IN_W'(-pq.ul) : IN_W'(pq.ul);
  assign aur_c = pq.ur[IN_W-1] ? IN_W'(-pq.ur) : IN_W'(pq.ur);
  assign spl_c = SPD_W'(aul_c) + SPD_W'(rootl);
  assign spr_c = SPD_W'(aur_c) + SPD_W'(rootr);

  logic             vs;
  pay_t             ps;
  logic [SPD_W-1:0] spd;

  // products from the swrf_mul instances
  logic signed [MB_W-1:0] spd_b, ul_b, ur_b, vl_b, vr_b, hl_b, hr_b;
  logic signed [MA_W-1:0] dh_a;
  assign spd_b = signed'(MB_W'(spd));
  assign ul_b  = MB_W'(ps.ul);
  assign ur_b  = MB_W'(ps.ur);
  assign vl_b  = MB_W'(ps.vl);
  assign vr_b  = MB_W'(ps.vr);
  assign hl_b  = MB_W'(ps.hl);
  assign hr_b  = MB_W'(ps.hr);
  assign dh_a  = MA_W'(ps.hr) - MA_W'(ps.hl);

  logic signed [MP_W-1:0] m1, n1, n2, n3, n4, n5, n6, t1, t2, t3, t4;

  swrf_mul u_m1 (.clk(clk), .ce(ce), .a(dh_a),   .b(spd_b), .p(m1));
  swrf_mul u_n1 (.clk(clk), .ce(ce), .a(ps.ql),  .b(ul_b),  .p(n1));
  swrf_mul u_n2 (.clk(clk), .ce(ce), .a(ps.qr),  .b(ur_b),  .p(n2));
  swrf_mul u_n3 (.clk(clk), .ce(ce), .a(ps.hgl), .b(hl_b),  .p(n3));
  swrf_mul u_n4 (.clk(clk), .ce(ce), .a(ps.hgr), .b(hr_b),  .p(n4));
  swrf_mul u_n5 (.clk(clk), .ce(ce), .a(ps.qr),  .b(spd_b), .p(n5));
  swrf_mul u_n6 (.clk(clk), .ce(ce), .a(ps.ql),  .b(spd_b), .p(n6));
  swrf_mul u_t1 (.clk(clk), .ce(ce), .a(ps.ql),  .b(vl_b),  .p(t1));
  swrf_mul u_t2 (.clk(clk), .ce(ce), .a(ps.qr),  .b(vr_b),  .p(t2));
  swrf_mul u_t3 (.clk(clk), .ce(ce), .a(ps.hvr), .b(spd_b), .p(t3));
  swrf_mul u_t4 (.clk(clk), .ce(ce), .a(ps.hvl), .b(spd_b), .p(t4));

  logic  vm [2];
  mpay_t pm [2];
  mpay_t ps_m;
  assign ps_m = '{ql: ps.ql, qr: ps.qr, zero: ps.zero};

  // ---------------- accumulate, round, saturate ----------------
  logic                    va1, va2, va3, za1, za2, z3;
  logic signed [ACC_W-1:0] m_a, n_a, n_b, n_c, t_a, t_b;
  logic signed [ACC_W-1:0] m_s, n_s, t_s;
  res_t                    o3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      vs  <= 1'b0;
      va1 <= 1'b0;
      va2 <= 1'b0;
      va3 <= 1'b0;
      for (int k = 0; k < SQ_STAGES; k++) begin
        vsq[k] <= 1'b0;
      end
      vm[0] <= 1'b0;
      vm[1] <= 1'b0;
    end else if (ce) begin
      v1 <= face.valid;
      vsq[0] <= v1;
      for (int k = 1; k < SQ_STAGES; k++) begin
        vsq[k] <= vsq[k-1];
      end
      vs    <= vsq[SQ_STAGES-1];
      vm[0] <= vs;
      vm[1] <= vm[0];
      va1   <= vm[1];
      va2   <= va1;
      va3   <= va2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p1  <= p_c;
      ghl <= ghl_c;
      ghr <= ghr_c;
      psq[0] <= p1;
      for (int k = 1; k < SQ_STAGES; k++) begin
        psq[k] <= psq[k-1];
      end
      ps  <= pq;
      spd <= (spl_c >= spr_c) ? spl_c : spr_c;
      pm[0] <= ps_m;
      pm[1] <= pm[0];
      // pairwise sums
      m_a <= ACC_W'(pm[1].ql) + ACC_W'(pm[1].qr) - ACC_W'(m1);
      n_a <= ACC_W'(n1) + ACC_W'(n2);
      n_b <= ACC_W'(n3) + ACC_W'(n4);
      n_c <= ACC_W'(n6) - ACC_W'(n5);
      t_a <= ACC_W'(t1) + ACC_W'(t2);
      t_b <= ACC_W'(t4) - ACC_W'(t3);
      za1 <= pm[1].zero;
      // totals with rounding bias
      m_s <= m_a + RND_M;
      n_s <= n_a + n_b + n_c + RND_N;
      t_s <= t_a + t_b + RND_N;
      za2 <= za1;
      // final shift and clamp
      z3        <= za2;
      o3.mass   <= za2 ? '0 : finish(m_s, SH_M);
      o3.normal <= za2 ? '0 : finish(n_s, SH_N);
      o3.trans  <= za2 ? '0 : finish(t_s, SH_N);
    end
  end

  // ---------------- two-entry output buffer ----------------
  logic [1:0] cnt, cnt_next;
  res_t       b0, b1;
  logic       push, pop;

  assign ce       = (cnt != 2'd2);
  assign push     = ce && va3;
  assign pop      = flux.valid && flux.ready;
  assign cnt_next = cnt + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    case (cnt)
      2'd0: begin
        if (push) b0 <= o3;
      end
      2'd1: begin
        if (push && pop) begin
          b0 <= o3;
        end else if (push) begin
          b1 <= o3;
        end
      end
      2'd2: begin
        if (pop) b0 <= b1;
      end
      default: begin
        b0 <= b0;
      end
    endcase
  end

  assign face.ready                = ce;
  assign flux.valid                = (cnt != 2'd0);
  assign flux.mass_flux            = b0.mass;
  assign flux.normal_momentum_flux = b0.normal;
  assign flux.trans_momentum_flux  = b0.trans;

  // ---------------- checks ----------------
  `SWRF_CHECK(a_dry_zero, va3 && z3, o3 == '0, "dry face gave nonzero flux")
  `SWRF_CHECK_NEXT(a_stall_hold, !ce, $stable(va3) && $stable(o3), "last stage moved in stall")
  `SWRF_CHECK_NEXT(a_full_hold, cnt == 2'd2 && !flux.ready, cnt == 2'd2 && $stable(b0),
                   "full buffer changed without a pop")

endmodule

// ----- rtl/swrf_isqrt.sv -----
// Pipelined floor integer square root, SQ_BPS root bits per stage
module swrf_isqrt (
  input  logic                         clk,
  input  logic                         ce,
  input  logic [swrf_pkg::SQ_IN_W-1:0] rad,
  output logic [swrf_pkg::SQ_OUT_W-1:0] root
);
  import swrf_pkg::*;

  logic [SQ_IN_W-1:0]  x_q    [SQ_STAGES];
  logic [SQ_REM_W-1:0] rem_q  [SQ_STAGES];
  logic [SQ_OUT_W-1:0] root_q [SQ_STAGES];
  logic [SQ_REM_W-1:0] rem_next  [SQ_STAGES];
  logic [SQ_OUT_W-1:0] root_next [SQ_STAGES];

  always_comb begin
    logic [SQ_IN_W-1:0]  x;
    logic [SQ_REM_W-1:0] r;
    logic [SQ_REM_W-1:0] trial;
    logic [SQ_OUT_W-1:0] q;
    int                  step;
    int                  i;
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        x = rad;
        r = '0;
        q = '0;
      end else begin
        x = x_q[k-1];
        r = rem_q[k-1];
        q = root_q[k-1];
      end
      for (int j = 0; j < SQ_BPS; j++) begin
        step = k * SQ_BPS + j;
        if (step < SQ_OUT_W) begin
          i = SQ_OUT_W - 1 - step;
          r = (r << 2) | SQ_REM_W'(x[2*i +: 2]);
          trial = (SQ_REM_W'(q) << 2) | SQ_REM_W'(1);
          if (r >= trial) begin
            r = r - trial;
            q = (q << 1) | SQ_OUT_W'(1);
          end else begin
            q = q << 1;
          end
        end
      end
      rem_next[k]  = r;
      root_next[k] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_q[0] <= rad;
      for (int k = 1; k < SQ_STAGES; k++) begin
        x_q[k] <= x_q[k-1];
      end
      for (int k = 0; k < SQ_STAGES; k++) begin
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
      end
    end
  end

  assign root = root_q[SQ_STAGES-1];

endmodule

// ----- rtl/swrf_mul.sv -----
// Two-stage signed multiplier, wide operand split into two partial products
module swrf_mul #(
  parameter int unsigned AW = swrf_pkg::MA_W,
  parameter int unsigned BW = swrf_pkg::MB_W
) (
  input  logic                 clk,
  input  logic                 ce,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  import swrf_pkg::*;

  localparam int unsigned HI_W = AW - LO_W;

  logic signed [LO_W+BW:0]   lo;
  logic signed [HI_W+BW-1:0] hi;

  always_ff @(posedge clk) begin
    if (ce) begin
      lo <= $signed({1'b0, a[LO_W-1:0]}) * b;
      hi <= $signed(a[AW-1:LO_W]) * b;
      p  <= ((AW+BW)'(hi) <<< LO_W) + (AW+BW)'(lo);
    end
  end

endmodule
